@@ hdl/sacc_pkg.sv @@
// Package for the set-associative cache with clock replacement.
// Holds port widths, register codes and reset values, and the controller/datapath structs.
// No dependencies.
package sacc_pkg;

  localparam int ADDR_W      = 32;
  localparam int OUT_WAY_W   = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BITS  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_WAYS_IN_USE = 1'b1;

  localparam logic [CFG_DATA_W-1:0] INDEX_BITS_RESET  = 3'd6;
  localparam logic [CFG_DATA_W-1:0] WAYS_IN_USE_RESET = 3'd4;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } status_t;

endpackage

@@ hdl/sacc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module sacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/sacc_dp.sv @@
// Datapath: configuration registers, tag and set-state memories, hit compare,
// clock-hand victim search and result register. Depends on sacc_pkg, sacc_ram.
module sacc_dp #(
  parameter int SETS      = 64,
  parameter int WAYS      = 4,
  parameter int ADDR_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sacc_pkg::cmd_t                        cmd,
  output sacc_pkg::status_t                     status,
  input  logic                                  cfg_we,
  input  logic [sacc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [sacc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [sacc_pkg::ADDR_W-1:0]           block_address,
  output logic                                  hit,
  output logic [sacc_pkg::OUT_WAY_W-1:0]        way
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CMP_W = WAY_W + 1;
  localparam int KMAX  = $clog2(SETS + 1) - 1;
  localparam int TAG_W = (ADDR_BITS < sacc_pkg::ADDR_W) ? ADDR_BITS : sacc_pkg::ADDR_W;
  localparam int EXT_W = TAG_W + SET_W;
  localparam int ROW_W = WAYS * TAG_W;
  localparam int ST_W  = 2 * WAYS + WAY_W;

  logic [sacc_pkg::CFG_DATA_W-1:0] index_bits;
  logic [sacc_pkg::CFG_DATA_W-1:0] ways_in_use;
  logic [SET_W-1:0]                clr_cnt;
  logic [SET_W-1:0]                set_q;
  logic [TAG_W-1:0]                tag_q;

  logic [3:0]       k;
  logic [CMP_W-1:0] n;
  logic [TAG_W-1:0] addr_m;
  logic [EXT_W-1:0] addr_ext;
  logic [SET_W-1:0] set_mask;
  logic [SET_W-1:0] set_in;
  logic [TAG_W-1:0] tag_in;

  logic [ROW_W-1:0] tags_rd;
  logic [ROW_W-1:0] tags_wr;
  logic [ST_W-1:0]  st_rd;
  logic [ST_W-1:0]  st_new;
  logic [ST_W-1:0]  st_wdata;
  logic [SET_W-1:0] st_waddr;
  logic             st_we;
  logic             tag_we;

  logic [WAYS-1:0]  valid_rd;
  logic [WAYS-1:0]  ref_rd;
  logic [WAY_W-1:0] hand_rd;
  logic [WAY_W-1:0] h0;
  logic             hit_f;
  logic [WAY_W-1:0] hit_w;
  logic             found;
  logic [WAY_W-1:0] vic;
  logic [WAYS-1:0]  clr_mask;
  logic [CMP_W-1:0] psum;
  logic [WAY_W-1:0] pos;

  always_comb begin
    if (int'(index_bits) < KMAX) begin
      k = 4'(index_bits);
    end else begin
      k = 4'(KMAX);
    end
    if (ways_in_use == '0) begin
      n = CMP_W'(1);
    end else if (int'(ways_in_use) > WAYS) begin
      n = CMP_W'(WAYS);
    end else begin
      n = CMP_W'(ways_in_use);
    end
    for (int b = 0; b < SET_W; b++) begin
      set_mask[b] = (b < int'(k));
    end
  end

  assign addr_m   = block_address[TAG_W-1:0];
  assign addr_ext = EXT_W'(addr_m);
  assign set_in   = addr_ext[SET_W-1:0] & set_mask;
  assign tag_in   = addr_m >> k;

  assign status.clear_last = (clr_cnt == SET_W'(SETS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits  <= sacc_pkg::INDEX_BITS_RESET;
      ways_in_use <= sacc_pkg::WAYS_IN_USE_RESET;
      clr_cnt     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sacc_pkg::REG_INDEX_BITS:  index_bits  <= cfg_data;
          sacc_pkg::REG_WAYS_IN_USE: ways_in_use <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear_wr) begin
        clr_cnt <= clr_cnt + SET_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      set_q <= set_in;
      tag_q <= tag_in;
    end
    if (cmd.finish) begin
      hit <= hit_f;
      way <= sacc_pkg::OUT_WAY_W'(hit_f ? hit_w : vic);
    end
  end

  assign valid_rd = st_rd[WAYS-1:0];
  assign ref_rd   = st_rd[2*WAYS-1:WAYS];
  assign hand_rd  = st_rd[ST_W-1:2*WAYS];

  // hit compare and clock sweep over the active ways
  always_comb begin
    hit_f    = 1'b0;
    hit_w    = '0;
    found    = 1'b0;
    clr_mask = '0;
    psum     = '0;
    pos      = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (CMP_W'(w) < n && valid_rd[w] && tags_rd[w*TAG_W +: TAG_W] == tag_q && !hit_f) begin
        hit_f = 1'b1;
        hit_w = WAY_W'(w);
      end
    end
    h0  = ({1'b0, hand_rd} >= n) ? '0 : hand_rd;
    vic = h0;
    for (int i = 0; i < WAYS; i++) begin
      if (CMP_W'(i) < n && !found) begin
        psum = {1'b0, h0} + CMP_W'(i);
        if (psum >= n) begin
          psum = psum - n;
        end
        pos = psum[WAY_W-1:0];
        if (!ref_rd[pos]) begin
          found = 1'b1;
          vic   = pos;
        end else begin
          clr_mask[pos] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    tags_wr = tags_rd;
    tags_wr[vic*TAG_W +: TAG_W] = tag_q;
    if (hit_f) begin
      st_new = {hand_rd, ref_rd | (WAYS'(1) << hit_w), valid_rd};
    end else begin
      st_new = {vic, (ref_rd & ~clr_mask) | (WAYS'(1) << vic), valid_rd | (WAYS'(1) << vic)};
    end
  end

  assign st_we    = cmd.clear_wr | cmd.finish;
  assign st_waddr = cmd.clear_wr ? clr_cnt : set_q;
  assign st_wdata = cmd.clear_wr ? '0 : st_new;
  assign tag_we   = cmd.finish & ~hit_f;

  sacc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (set_q),
    .wdata (tags_wr),
    .re    (cmd.accept),
    .raddr (set_in),
    .rdata (tags_rd)
  );

  sacc_ram #(
    .WIDTH (ST_W),
    .DEPTH (SETS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (cmd.accept),
    .raddr (set_in),
    .rdata (st_rd)
  );

endmodule

@@ hdl/sacc_ctrl.sv @@
// Controller: set-state clearing pass, access acceptance, lookup completion
// and result valid. Depends on sacc_pkg.
module sacc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              access_valid,
  output logic              access_stall,
  output logic              result_valid,
  input  logic              result_stall,
  output sacc_pkg::cmd_t    cmd,
  input  sacc_pkg::status_t status
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_t;

  state_t state;

  assign access_stall = (state != S_IDLE);

  always_comb begin
    cmd.clear_wr = (state == S_CLEAR);
    cmd.accept   = (state == S_IDLE) && access_valid;
    cmd.finish   = (state == S_LOOKUP) && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (status.clear_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.accept) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (cmd.finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/set_assoc_cache_clock_replace_unit.sv @@
// Top level of the set-associative cache lookup with clock replacement.
// Depends on sacc_pkg, sacc_ctrl, sacc_dp.
//
// Each accepted block address is looked up in one set and answered with a hit flag
// and the way that hit or was filled; one word in, one word out. The set's tag row
// and state row (valid bits, reference bits, clock hand) are read from memory in the
// accept cycle; the compare, the victim search over the ways and the write-back of
// the set follow in the lookup state, which waits while a held result fills the
// output register, and the next access is taken after the write-back. A finished
// result waits in the output register while the next access is accepted. After reset
// the block clears the set-state memory, one set per cycle, and takes no access until
// every set is cleared; configuration writes are taken at any time but belong in idle periods.
module set_assoc_cache_clock_replace_unit #(
  parameter int SETS      = 64,
  parameter int WAYS      = 4,
  parameter int ADDR_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             access_valid,
  output logic                             access_stall,
  input  logic [sacc_pkg::ADDR_W-1:0]      block_address,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             hit,
  output logic [sacc_pkg::OUT_WAY_W-1:0]   way,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sacc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sacc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sacc_pkg::cmd_t    cmd;
  sacc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  sacc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .access_valid (access_valid),
    .access_stall (access_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  sacc_dp #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .block_address (block_address),
    .hit           (hit),
    .way           (way)
  );

endmodule

@@ bench/set_assoc_cache_clock_replace_unit_checker.sv @@
`timescale 1ns / 1ps
// Checker for set_assoc_cache_clock_replace_unit: watches the access, result and register
// channels, keeps its own copy of tags, valid/reference bits and clock hands, and compares
// every result word with the predicted one. Depends on sacc_pkg.
module set_assoc_cache_clock_replace_unit_checker #(
  parameter int SETS      = 64,
  parameter int WAYS      = 4,
  parameter int ADDR_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             access_valid,
  input  logic                             access_stall,
  input  logic [sacc_pkg::ADDR_W-1:0]      block_address,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  logic                             hit,
  input  logic [sacc_pkg::OUT_WAY_W-1:0]   way,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [sacc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sacc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               pending,
  output int                               hit_count,
  output int                               miss_count
);

  typedef struct packed {
    logic                           hit;
    logic [sacc_pkg::OUT_WAY_W-1:0] way;
  } lookup_t;

  localparam logic [63:0] ADDR_MASK = ~64'd0 >> (64 - ADDR_BITS);

  logic [63:0]                     tag_mem [SETS][WAYS];
  bit                              line_valid [SETS][WAYS];
  bit                              ref_bit [SETS][WAYS];
  logic [1:0]                      hand [SETS];
  logic [sacc_pkg::CFG_DATA_W-1:0] index_bits_q;
  logic [sacc_pkg::CFG_DATA_W-1:0] ways_q;
  lookup_t                         expected_words [$];

  function automatic int max_index_bits();
    int k;
    k = 0;
    while (k < 12 && (64'd1 << (k + 1)) <= SETS) k++;
    return k;
  endfunction

  // One access: hit search over the active ways, else clock sweep and fill.
  function automatic lookup_t lookup_and_fill(logic [sacc_pkg::ADDR_W-1:0] addr_in);
    logic [63:0] addr;
    logic [63:0] tag;
    int          k;
    int          n;
    int          set_i;
    int          h;
    bit          found;
    lookup_t     r;
    addr = {32'd0, addr_in} & ADDR_MASK;
    k = (int'(index_bits_q) < max_index_bits()) ? int'(index_bits_q) : max_index_bits();
    n = (ways_q == 0) ? 1 : ((int'(ways_q) > WAYS) ? WAYS : int'(ways_q));
    set_i = int'(addr & ((64'd1 << k) - 1));
    if (set_i >= SETS) set_i = 0;
    tag = addr >> k;
    found = 0;
    r = '0;
    for (int w = 0; w < n; w++) begin
      if (!found && line_valid[set_i][w] && tag_mem[set_i][w] == tag) begin
        found = 1;
        ref_bit[set_i][w] = 1;
        r.hit = 1'b1;
        r.way = w[sacc_pkg::OUT_WAY_W-1:0];
      end
    end
    if (!found) begin
      h = int'(hand[set_i]);
      if (h >= n) h = 0;
      while (ref_bit[set_i][h]) begin
        ref_bit[set_i][h] = 0;
        h = (h + 1 < n) ? h + 1 : 0;
      end
      hand[set_i] = h[1:0];
      tag_mem[set_i][h] = tag;
      line_valid[set_i][h] = 1;
      ref_bit[set_i][h] = 1;
      r.hit = 1'b0;
      r.way = h[sacc_pkg::OUT_WAY_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      for (int s = 0; s < SETS; s++) begin
        hand[s] = '0;
        for (int w = 0; w < WAYS; w++) begin
          line_valid[s][w] = 0;
          ref_bit[s][w] = 0;
          tag_mem[s][w] = '0;
        end
      end
      index_bits_q = sacc_pkg::INDEX_BITS_RESET;
      ways_q = sacc_pkg::WAYS_IN_USE_RESET;
      expected_words.delete();
      fail_count = 0;
      hit_count = 0;
      miss_count = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result word with nothing outstanding: hit=%0b way=%0d",
                     $realtime, hit, way);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (hit !== want.hit || way !== want.way) begin
            if (fail_count < 10)
              $display("%0t: mismatch: hit exp %0b got %0b, way exp %0d got %0d",
                       $realtime, want.hit, hit, want.way, way);
            fail_count++;
          end
        end
      end
      if (access_valid && !access_stall) begin
        want = lookup_and_fill(block_address);
        if (want.hit) hit_count++;
        else miss_count++;
        expected_words = {expected_words, want};
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sacc_pkg::REG_INDEX_BITS:  index_bits_q = cfg_data;
          sacc_pkg::REG_WAYS_IN_USE: ways_q = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_words.size();
  end

endmodule

@@ bench/set_assoc_cache_clock_replace_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for set_assoc_cache_clock_replace_unit: drives block addresses, register
// writes and result stalls, and gives the verdict from the checker's failure count.
// Depends on sacc_pkg, set_assoc_cache_clock_replace_unit and its checker.
module set_assoc_cache_clock_replace_unit_tb;

  localparam int SETS        = 64;
  localparam int WAYS        = 4;
  localparam int ADDR_BITS   = 32;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 160;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             access_valid = 1'b0;
  logic                             access_stall;
  logic [sacc_pkg::ADDR_W-1:0]      block_address = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic                             hit;
  logic [sacc_pkg::OUT_WAY_W-1:0]   way;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [sacc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sacc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_count;
  int pending;
  int hit_count;
  int miss_count;
  int cycle_count = 0;
  int sent_count = 0;
  int settings_count = 0;
  int gap_mode = 1;
  int stall_mode = 1;
  bit hold_req = 0;
  int cur_index_bits = 6;
  logic [sacc_pkg::ADDR_W-1:0] recent_addrs [$];

  set_assoc_cache_clock_replace_unit #(
    .SETS(SETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .access_valid(access_valid), .access_stall(access_stall),
    .block_address(block_address),
    .result_valid(result_valid), .result_stall(result_stall),
    .hit(hit), .way(way),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  set_assoc_cache_clock_replace_unit_checker #(
    .SETS(SETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS)
  ) checker_i (
    .clk(clk), .rst(rst),
    .access_valid(access_valid), .access_stall(access_stall),
    .block_address(block_address),
    .result_valid(result_valid), .result_stall(result_stall),
    .hit(hit), .way(way),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .hit_count(hit_count), .miss_count(miss_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: short random stalls, a few long ones, and the requested hold-off.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end else if (stall_mode != 0 && $urandom_range(0, 24) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(8, 40)) @(negedge clk);
      end
      result_stall <= (stall_mode == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  function automatic int pick_gap();
    int r;
    if (gap_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_address(input logic [sacc_pkg::ADDR_W-1:0] a);
    int gap;
    access_valid <= 1'b1;
    block_address <= a;
    do @(posedge clk); while (access_stall);
    sent_count++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      access_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [sacc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [sacc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Called at a negedge with the access channel idle.
  task automatic configure(input logic [sacc_pkg::CFG_DATA_W-1:0] ib,
                           input logic [sacc_pkg::CFG_DATA_W-1:0] wu);
    access_valid <= 1'b0;
    wait_idle();
    write_reg(sacc_pkg::REG_INDEX_BITS, ib);
    write_reg(sacc_pkg::REG_WAYS_IN_USE, wu);
    cfg_valid <= 1'b0;
    cur_index_bits = (ib > 6) ? 6 : int'(ib);
    settings_count++;
  endtask

  // Mostly reuse and near-conflict addresses so sets fill, hit and evict.
  function automatic logic [sacc_pkg::ADDR_W-1:0] next_block_address();
    int r;
    logic [sacc_pkg::ADDR_W-1:0] a;
    r = $urandom_range(0, 99);
    if (r < 55 && recent_addrs.size() > 0)
      return recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
    if (r < 90)
      a = (sacc_pkg::ADDR_W'($urandom_range(0, 11)) << cur_index_bits)
          | sacc_pkg::ADDR_W'($urandom_range(0, 7));
    else
      a = $urandom();
    recent_addrs = {recent_addrs, a};
    if (recent_addrs.size() > 24) void'(recent_addrs.pop_front());
    return a;
  endfunction

  initial begin : stimulus
    logic [sacc_pkg::CFG_DATA_W-1:0] ib_list [8] =
      '{3'd6, 3'd0, 3'd7, 3'd3, 3'd1, 3'd2, 3'd6, 3'd4};
    logic [sacc_pkg::CFG_DATA_W-1:0] wu_list [8] =
      '{3'd4, 3'd1, 3'd7, 3'd2, 3'd0, 3'd3, 3'd5, 3'd4};
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: fill a set, hit, full sweep eviction, extreme addresses
    configure(3'd6, 3'd4);
    send_address(32'h0000_0000);
    send_address(32'h0000_0000);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0040);
    send_address(32'h0000_0080);
    send_address(32'h0000_00C0);
    send_address(32'h0000_0000);
    send_address(32'h0000_0100);
    send_address(32'h0000_00C0);
    send_address(32'hFFFF_FFC0);
    // fewer active ways after the set was filled
    configure(3'd6, 3'd2);
    send_address(32'h0000_0000);
    send_address(32'h0000_0040);
    send_address(32'h0000_0200);
    send_address(32'h0000_003F);
    // index too wide, zero ways acts as one
    configure(3'd7, 3'd0);
    send_address(32'h0000_0005);
    send_address(32'h0000_0005);
    send_address(32'h0000_0045);
    send_address(32'h0000_0005);
    // single set, too many ways acts as all
    configure(3'd0, 3'd7);
    send_address(32'h0000_0001);
    send_address(32'h0000_0002);
    send_address(32'h0000_0003);
    send_address(32'h0000_0004);
    send_address(32'h0000_0005);
    send_address(32'h0000_0001);
    send_address(32'hFFFF_FFFF);

    for (int p = 0; p < 8; p++) begin
      configure(ib_list[p], wu_list[p]);
      recent_addrs.delete();
      gap_mode = (p == 2) ? 0 : 1;
      stall_mode = (p == 2) ? 0 : 1;
      if (p == 4) begin
        gap_mode = 0;
        hold_req = 1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) send_address(next_block_address());
    end

    access_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Ran %0d accesses (%0d hits, %0d misses) across %0d register settings,",
             sent_count, hit_count, miss_count, settings_count);
    $display("with random gaps and stalls on both sides and one long result hold-off.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
